### sv/pcksum_pkg.sv
// Shared types, constants and the CRC byte function for the POSIX cksum core.
// No dependencies; every other file imports this package.
package pcksum_pkg;

	localparam int CRC_W          = 32;
	localparam int OUT_COUNT_W    = 40;
	localparam int COUNT_BITS_DEF = 40;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [CRC_W-1:0]       checksum;
		logic [OUT_COUNT_W-1:0] byte_count;
		logic                   count_overflow;
	} out_item_t;

	typedef enum logic {
		ST_RUN,
		ST_FOLD
	} ctrl_state_t;

	typedef struct packed {
		logic take;       // item accepted this cycle
		logic start_fold; // accepted item is the last of its message
		logic fold_step;  // fold one count byte into the CRC
		logic load_out;   // capture the finished result
	} dp_cmd_t;

	typedef struct packed {
		logic rest_zero;  // no count bytes left to fold
	} dp_status_t;

	// MSB-first CRC update by one byte, one shift per bit.
	function automatic logic [CRC_W-1:0] crc_take_byte(logic [CRC_W-1:0] crc, logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 24'h0};
		for (int i = 0; i < 8; i++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### sv/pcksum_in_if.sv
// Message channel: valid/ready handshake carrying one message byte item.
// Depends on pcksum_pkg.
interface pcksum_in_if;
	import pcksum_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

### sv/pcksum_out_if.sv
// Result channel: valid/ready handshake carrying one checksum result item.
// Depends on pcksum_pkg.
interface pcksum_out_if;
	import pcksum_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

### sv/pcksum_dp.sv
// Datapath: running CRC and byte counter, length fold and result register.
// Depends on pcksum_pkg; driven by pcksum_ctrl commands.
module pcksum_dp #(
	parameter int COUNT_BITS = pcksum_pkg::COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pcksum_pkg::in_item_t   in_item,
	input  pcksum_pkg::dp_cmd_t    cmd,
	output pcksum_pkg::dp_status_t status,
	output pcksum_pkg::out_item_t  out_item
);
	import pcksum_pkg::*;

	localparam int EXT_W = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;

	logic [CRC_W-1:0]       crc_q;
	logic [COUNT_BITS-1:0]  cnt_q;
	logic                   ovf_q;
	logic [CRC_W-1:0]       fold_crc_q;
	logic [COUNT_BITS-1:0]  rest_q;
	logic                   fold_ovf_q;
	logic [OUT_COUNT_W-1:0] fold_cnt_q;
	out_item_t              out_q;

	logic [CRC_W-1:0]      crc_in;
	logic [COUNT_BITS-1:0] cnt_in;
	logic                  ovf_in;
	logic                  cnt_max;
	logic [EXT_W-1:0]      cnt_ext;

	always_comb begin
		cnt_max = &cnt_q;
		crc_in  = in_item.byte_valid ? crc_take_byte(crc_q, in_item.data_byte) : crc_q;
		cnt_in  = (in_item.byte_valid && !cnt_max) ? cnt_q + COUNT_BITS'(1) : cnt_q;
		ovf_in  = ovf_q | (in_item.byte_valid & cnt_max);
		cnt_ext = EXT_W'(cnt_in);
	end

	// Running message state; cleared when a message closes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.take) begin
			if (cmd.start_fold) begin
				crc_q <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				crc_q <= crc_in;
				cnt_q <= cnt_in;
				ovf_q <= ovf_in;
			end
		end
	end

	// Length fold: least significant count byte first, until the rest is zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q <= '0;
		end else if (cmd.start_fold) begin
			rest_q <= cnt_in;
		end else if (cmd.fold_step) begin
			rest_q <= rest_q >> 8;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_fold) begin
			fold_crc_q <= crc_in;
			fold_ovf_q <= ovf_in;
			fold_cnt_q <= cnt_ext[OUT_COUNT_W-1:0];
		end else if (cmd.fold_step) begin
			fold_crc_q <= crc_take_byte(fold_crc_q, rest_q[7:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.checksum       <= fold_ovf_q ? '0 : (fold_crc_q ^ CRC_ONES);
			out_q.byte_count     <= fold_cnt_q;
			out_q.count_overflow <= fold_ovf_q;
		end
	end

	assign status.rest_zero = (rest_q == '0);
	assign out_item         = out_q;

endmodule

### sv/pcksum_ctrl.sv
// Controller: accepts items, sequences the length fold and owns result valid.
// Depends on pcksum_pkg; commands pcksum_dp.
module pcksum_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_last,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  pcksum_pkg::dp_status_t status,
	output pcksum_pkg::dp_cmd_t    cmd
);
	import pcksum_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (in_valid && in_last) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (status.rest_zero && slot_free) begin
					state_d = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd.take       = 1'b0;
		cmd.start_fold = 1'b0;
		cmd.fold_step  = 1'b0;
		cmd.load_out   = 1'b0;
		case (state_q)
			ST_RUN: begin
				in_ready       = 1'b1;
				cmd.take       = in_valid;
				cmd.start_fold = in_valid && in_last;
			end
			ST_FOLD: begin
				cmd.fold_step = !status.rest_zero;
				cmd.load_out  = status.rest_zero && slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("result not presented after load");

	a_no_take_in_fold: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.take && (cmd.fold_step || cmd.load_out)))
		else $error("item taken during fold");

	a_last_enters_fold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_fold |=> state_q == ST_FOLD)
		else $error("last item did not start fold");

	a_fold_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD && !status.rest_zero) |=> state_q == ST_FOLD)
		else $error("fold left with count bytes pending");

endmodule

### sv/posix_cksum_crc32_core.sv
// POSIX cksum CRC-32 core: one message byte per item, one item accepted per cycle outside the fold.
// A last item starts the length fold: the count bytes up to the highest nonzero one
// (0 to ceil(COUNT_BITS/8) of them) are folded into the CRC, then the result register is loaded.
// No item is accepted during the fold; a waiting result holds the load, and the input with it.
// Reset clears CRC, byte counter, overflow flag, fold and result valid.
module posix_cksum_crc32_core #(
	parameter int COUNT_BITS = pcksum_pkg::COUNT_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	pcksum_in_if.sink    msg,
	pcksum_out_if.source result
);
	import pcksum_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	pcksum_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (msg.valid),
		.in_last   (msg.item.last),
		.in_ready  (msg.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	pcksum_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (msg.item),
		.cmd      (cmd),
		.status   (status),
		.out_item (result.item)
	);

endmodule
